>>> hw/rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/mbta_pkg.sv
// ============================================================================
// mbta_pkg
// Types, constants and helper functions of the timestamp aligner.
// ============================================================================
package mbta_pkg;

	localparam int MAX_BOARDS = 6;
	localparam int TS_W       = 48;
	localparam int DEV_W      = 50;
	localparam int WIDE_W     = 52;
	localparam int REC_W      = 32;
	localparam int BC_W       = 3;
	localparam int WIN_W      = 30;
	localparam int NOM_W      = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [BC_W-1:0]  BOARD_COUNT_RST    = 3'd6;
	localparam logic [WIN_W-1:0] MATCH_WINDOW_RST   = 30'd10000000;
	localparam logic [NOM_W-1:0] NOMINAL_PERIOD_RST = 32'd1000000000;

	localparam logic signed [WIDE_W-1:0] DEV_MAX_WIDE = 52'sh1_FFFF_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] DEV_MIN_WIDE = 52'shE_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOARD_COUNT    = 2'd0,
		CFG_MATCH_WINDOW   = 2'd1,
		CFG_NOMINAL_PERIOD = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_SEED  = 1'b0,
		OP_ALIGN = 1'b1
	} opcode_t;

	typedef logic signed [DEV_W-1:0]  dev_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [TS_W-1:0]          stamp_t;

	typedef struct packed {
		logic step;
		logic seed;
		logic active;
	} board_ctl_t;

	typedef struct packed {
		logic near_nominal;
		logic matched;
	} board_stat_t;

	typedef struct packed {
		logic valid;
		dev_t value;
	} cand_t;

	function automatic dev_t sat_dev(input wide_t v);
		dev_t r;
		if (v > DEV_MAX_WIDE) begin
			r = DEV_MAX_WIDE[DEV_W-1:0];
		end else if (v < DEV_MIN_WIDE) begin
			r = DEV_MIN_WIDE[DEV_W-1:0];
		end else begin
			r = v[DEV_W-1:0];
		end
		return r;
	endfunction

	function automatic wide_t widen(input dev_t v);
		return wide_t'(v);
	endfunction

	function automatic cand_t min_pair(input cand_t a, input cand_t b);
		cand_t r;
		if (a.valid && b.valid) begin
			r = (b.value < a.value) ? b : a;
		end else if (a.valid) begin
			r = a;
		end else begin
			r = b;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/mbta_in_if.sv
// ============================================================================
// mbta_in_if
// Input channel: opcode and the next pending timestamp of each board.
// ============================================================================
interface mbta_in_if;
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [mbta_pkg::TS_W-1:0] ts_board0;
	logic [mbta_pkg::TS_W-1:0] ts_board1;
	logic [mbta_pkg::TS_W-1:0] ts_board2;
	logic [mbta_pkg::TS_W-1:0] ts_board3;
	logic [mbta_pkg::TS_W-1:0] ts_board4;
	logic [mbta_pkg::TS_W-1:0] ts_board5;

	modport source (
		output valid, opcode, ts_board0, ts_board1, ts_board2,
		       ts_board3, ts_board4, ts_board5,
		input  ready
	);

	modport sink (
		input  valid, opcode, ts_board0, ts_board1, ts_board2,
		       ts_board3, ts_board4, ts_board5,
		output ready
	);
endinterface

>>> hw/rtl/mbta_out_if.sv
// ============================================================================
// mbta_out_if
// Result channel: one aligned record per input word.
// ============================================================================
interface mbta_out_if;
	logic                                valid;
	logic                                ready;
	logic [mbta_pkg::REC_W-1:0]          record_id;
	logic [mbta_pkg::MAX_BOARDS-1:0]     match_mask;
	logic [mbta_pkg::BC_W-1:0]           match_count;
	logic signed [mbta_pkg::DEV_W-1:0]   min_deviation;
	logic                                no_reference;

	modport source (
		output valid, record_id, match_mask, match_count, min_deviation, no_reference,
		input  ready
	);

	modport sink (
		input  valid, record_id, match_mask, match_count, min_deviation, no_reference,
		output ready
	);
endinterface

>>> hw/rtl/multi_board_timestamp_aligner.sv
// ============================================================================
// multi_board_timestamp_aligner
// Aligns the timestamp streams of up to six boards into numbered records.
// ============================================================================
// Input words arrive on in_ch (valid/ready); an opcode of seed loads the
// previous timestamps and restarts the record count, an opcode of align
// compares each board's next timestamp against the nominal period and the
// chosen minimum deviation. One record word leaves on out_ch for every
// input word; match_mask tells the feeder which boards advance.
// Registers are written on cfg_wr_en with cfg_index and cfg_data; the user
// must do so only while no word is in flight; the block does not enforce it.
// A word accepted on in_ch is held in the input register and then moves to
// the result register, from which out_ch presents its record word.
// Throughput is one word per cycle while the receiver does not stall: each
// board lane closes its state loop (deviation, minimum tree, match, sum
// update) in a single pass between the input and result registers.
// Reset clears the board state, the record counter and the valid flags of
// both channel registers, and loads the register defaults. While the
// receiver stalls, the result register holds and one more word can wait in
// the input register; then in_ch.ready drops.
// ============================================================================
`include "assert_macros.svh"

module multi_board_timestamp_aligner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mbta_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbta_pkg::CFG_DATA_W-1:0]     cfg_data,
	mbta_in_if.sink                             in_ch,
	mbta_out_if.source                          out_ch
);

	logic [mbta_pkg::BC_W-1:0]  board_count_q;
	logic [mbta_pkg::WIN_W-1:0] match_window_q;
	logic [mbta_pkg::NOM_W-1:0] nominal_period_q;

	logic                    valid_s1;
	mbta_pkg::opcode_t       op_s1;
	mbta_pkg::stamp_t        ts_s1 [mbta_pkg::MAX_BOARDS];

	logic                              out_valid_q;
	logic [mbta_pkg::REC_W-1:0]        out_rec_q;
	logic [mbta_pkg::MAX_BOARDS-1:0]   out_mask_q;
	logic [mbta_pkg::BC_W-1:0]         out_count_q;
	mbta_pkg::dev_t                    out_min_q;
	logic                              out_noref_q;
	logic [mbta_pkg::REC_W-1:0]        next_rec_q;

	logic                              advance;
	logic [mbta_pkg::BC_W-1:0]         n_active;
	logic [mbta_pkg::MAX_BOARDS-1:0]   active;
	logic [mbta_pkg::MAX_BOARDS-1:0]   near;
	logic [mbta_pkg::MAX_BOARDS-1:0]   matched;
	logic [mbta_pkg::MAX_BOARDS-1:0]   eligible;
	mbta_pkg::dev_t                    dev [mbta_pkg::MAX_BOARDS];
	mbta_pkg::board_ctl_t              ctl [mbta_pkg::MAX_BOARDS];
	mbta_pkg::board_stat_t             stat [mbta_pkg::MAX_BOARDS];
	mbta_pkg::cand_t                   cand [mbta_pkg::MAX_BOARDS];
	mbta_pkg::cand_t                   m01, m23, m45, m03, m05;
	mbta_pkg::dev_t                    min_dev;
	logic                              have_ref;
	logic [mbta_pkg::MAX_BOARDS-1:0]   mask_c;
	logic [mbta_pkg::BC_W-1:0]         count_c;
	logic                              seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_count_q    <= mbta_pkg::BOARD_COUNT_RST;
			match_window_q   <= mbta_pkg::MATCH_WINDOW_RST;
			nominal_period_q <= mbta_pkg::NOMINAL_PERIOD_RST;
		end else if (cfg_wr_en) begin
			case (mbta_pkg::cfg_reg_t'(cfg_index))
				mbta_pkg::CFG_BOARD_COUNT: begin
					board_count_q <= cfg_data[mbta_pkg::BC_W-1:0];
				end
				mbta_pkg::CFG_MATCH_WINDOW: begin
					match_window_q <= cfg_data[mbta_pkg::WIN_W-1:0];
				end
				mbta_pkg::CFG_NOMINAL_PERIOD: begin
					nominal_period_q <= cfg_data[mbta_pkg::NOM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1    <= mbta_pkg::opcode_t'(in_ch.opcode);
			ts_s1[0] <= in_ch.ts_board0;
			ts_s1[1] <= in_ch.ts_board1;
			ts_s1[2] <= in_ch.ts_board2;
			ts_s1[3] <= in_ch.ts_board3;
			ts_s1[4] <= in_ch.ts_board4;
			ts_s1[5] <= in_ch.ts_board5;
		end
	end

	always_comb begin
		n_active = (board_count_q > mbta_pkg::BC_W'(mbta_pkg::MAX_BOARDS)) ?
			mbta_pkg::BC_W'(mbta_pkg::MAX_BOARDS) : board_count_q;
		for (int i = 0; i < mbta_pkg::MAX_BOARDS; i++) begin
			active[i] = mbta_pkg::BC_W'(i) < n_active;
			ctl[i].step = advance;
			ctl[i].seed = (op_s1 == mbta_pkg::OP_SEED);
			ctl[i].active = active[i];
		end
	end

	for (genvar g = 0; g < mbta_pkg::MAX_BOARDS; g++) begin : g_board
		mbta_board u_board (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[g]),
			.next_ts (ts_s1[g]),
			.window  (match_window_q),
			.nominal (nominal_period_q),
			.min_dev (min_dev),
			.dev     (dev[g]),
			.stat    (stat[g])
		);
		assign near[g]    = stat[g].near_nominal;
		assign matched[g] = stat[g].matched;
	end

	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < mbta_pkg::MAX_BOARDS; i++) begin
			seen = seen | near[i];
			eligible[i] = seen && active[i];
			cand[i].valid = eligible[i];
			cand[i].value = dev[i];
		end
		m01 = mbta_pkg::min_pair(cand[0], cand[1]);
		m23 = mbta_pkg::min_pair(cand[2], cand[3]);
		m45 = mbta_pkg::min_pair(cand[4], cand[5]);
		m03 = mbta_pkg::min_pair(m01, m23);
		m05 = mbta_pkg::min_pair(m03, m45);
		have_ref = |near;
		min_dev = m05.valid ? m05.value : '0;
		mask_c = (op_s1 == mbta_pkg::OP_SEED) ? active : matched;
		count_c = '0;
		for (int i = 0; i < mbta_pkg::MAX_BOARDS; i++) begin
			count_c = count_c + mbta_pkg::BC_W'(mask_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			next_rec_q  <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (op_s1 == mbta_pkg::OP_SEED) begin
					next_rec_q <= mbta_pkg::REC_W'(1);
				end else begin
					next_rec_q <= next_rec_q + mbta_pkg::REC_W'(1);
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_mask_q  <= mask_c;
			out_count_q <= count_c;
			if (op_s1 == mbta_pkg::OP_SEED) begin
				out_rec_q   <= '0;
				out_min_q   <= '0;
				out_noref_q <= 1'b0;
			end else begin
				out_rec_q   <= next_rec_q;
				out_min_q   <= min_dev;
				out_noref_q <= !have_ref;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.record_id     = out_rec_q;
	assign out_ch.match_mask    = out_mask_q;
	assign out_ch.match_count   = out_count_q;
	assign out_ch.min_deviation = out_min_q;
	assign out_ch.no_reference  = out_noref_q;

	`MBTA_ASSERT_IMP(a_count_matches_mask, out_valid_q,
		(mbta_pkg::BC_W'($countones(out_mask_q)) == out_count_q),
		"match_count differs from the population of match_mask")
	`MBTA_ASSERT_IMP(a_noref_zero_min, out_valid_q && out_noref_q, out_min_q == '0,
		"minimum deviation is nonzero without a reference board")
	`MBTA_ASSERT_IMP(a_ready_when_empty, !out_valid_q, in_ch.ready,
		"input stalled while the result register is empty")
	`MBTA_ASSERT_NEXT(a_record_step, advance && (op_s1 == mbta_pkg::OP_ALIGN),
		next_rec_q == $past(next_rec_q) + mbta_pkg::REC_W'(1),
		"record counter did not advance after an align word")
	`MBTA_ASSERT_NEXT(a_seed_restart, advance && (op_s1 == mbta_pkg::OP_SEED),
		next_rec_q == mbta_pkg::REC_W'(1) && out_rec_q == '0,
		"seed word did not restart the record numbering")

endmodule

>>> hw/rtl/mbta_board.sv
// ============================================================================
// mbta_board
// One board lane: holds the previous timestamp and the unmatched sum,
// forms the deviation, and decides the match against the chosen minimum.
// ============================================================================
module mbta_board (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbta_pkg::board_ctl_t            ctl,
	input  mbta_pkg::stamp_t                next_ts,
	input  logic [mbta_pkg::WIN_W-1:0]      window,
	input  logic [mbta_pkg::NOM_W-1:0]      nominal,
	input  mbta_pkg::dev_t                  min_dev,
	output mbta_pkg::dev_t                  dev,
	output mbta_pkg::board_stat_t           stat
);

	mbta_pkg::stamp_t prev_q;
	mbta_pkg::dev_t   sum_q;

	mbta_pkg::wide_t raw;
	mbta_pkg::wide_t win_w;
	mbta_pkg::wide_t nom_diff;
	mbta_pkg::wide_t min_diff;
	mbta_pkg::dev_t  sum_next;

	always_comb begin
		raw = $signed({4'b0, next_ts}) - $signed({4'b0, prev_q}) - mbta_pkg::widen(sum_q);
		dev = mbta_pkg::sat_dev(raw);
		win_w = $signed({22'b0, window});
		nom_diff = mbta_pkg::widen(dev) - $signed({20'b0, nominal});
		min_diff = mbta_pkg::widen(dev) - mbta_pkg::widen(min_dev);
		stat.near_nominal = ctl.active && (nom_diff < win_w) && (nom_diff > -win_w);
		stat.matched = ctl.active && (min_diff < win_w) && (min_diff > -win_w);
		sum_next = mbta_pkg::sat_dev(mbta_pkg::widen(sum_q) + mbta_pkg::widen(min_dev));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
		end else if (ctl.step) begin
			if (ctl.seed) begin
				prev_q <= next_ts;
				sum_q  <= '0;
			end else if (ctl.active) begin
				if (stat.matched) begin
					prev_q <= next_ts;
					sum_q  <= '0;
				end else begin
					sum_q <= sum_next;
				end
			end
		end
	end

endmodule
